// ===== hdl/amu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Atomic memory unit package
// Shared types, operation codes and sizes of the atomic memory unit.
// ----------------------------------------------------------------------------
package amu_pkg;

	// Field widths of the request and response items.
	localparam int FUNC_W       = 4;
	localparam int INDEX_W      = 10;
	localparam int WORD_W       = 32;

	// Default number of words in the store.
	localparam int STORE_WORDS_DEF = 1024;

	// Operation codes.
	localparam logic [FUNC_W-1:0] OP_CAS  = 4'd0;
	localparam logic [FUNC_W-1:0] OP_XCHG = 4'd1;
	localparam logic [FUNC_W-1:0] OP_ADDU = 4'd2;
	localparam logic [FUNC_W-1:0] OP_INC  = 4'd3;
	localparam logic [FUNC_W-1:0] OP_DEC  = 4'd4;
	localparam logic [FUNC_W-1:0] OP_MIN  = 4'd5;
	localparam logic [FUNC_W-1:0] OP_MAX  = 4'd6;
	localparam logic [FUNC_W-1:0] OP_AND  = 4'd7;
	localparam logic [FUNC_W-1:0] OP_OR   = 4'd8;
	localparam logic [FUNC_W-1:0] OP_XOR  = 4'd9;

	// Request item.
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [INDEX_W-1:0] word_index;
		logic [WORD_W-1:0]  swap_value;
		logic [WORD_W-1:0]  operand;
	} amu_req_t;

	// Response item.
	typedef struct packed {
		logic [WORD_W-1:0] return_value;
		logic              did_write;
		logic              bad_func;
	} amu_rsp_t;

	// Outcome of one read-modify-write: the word to store and the response.
	typedef struct packed {
		logic [WORD_W-1:0] new_word;
		amu_rsp_t          rsp;
	} amu_upd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_ADDR,
		S_EXEC
	} amu_state_t;

endpackage : amu_pkg
`default_nettype wire

// ===== hdl/amu_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Atomic memory unit operation logic
// Computes the new word and the response of one atomic operation from the
// old word and the request.
// ----------------------------------------------------------------------------
module amu_alu
	import amu_pkg::*;
(
	input  wire amu_req_t          req,
	input  wire [WORD_W-1:0]       old_word,
	output amu_upd_t               upd
);

	// Shared adder for add-unsigned, increment and decrement.
	logic [WORD_W-1:0] add_b;
	logic [WORD_W-1:0] sum;
	logic              old_lt;

	always_comb begin
		case (req.func)
			OP_INC:  add_b = WORD_W'(1);
			OP_DEC:  add_b = '1;
			default: add_b = req.operand;
		endcase
	end

	assign sum    = old_word + add_b;
	assign old_lt = old_word < req.operand;

	// Operation select.
	always_comb begin
		upd.new_word         = '0;
		upd.rsp.return_value = '0;
		upd.rsp.did_write    = 1'b1;
		upd.rsp.bad_func     = 1'b0;
		case (req.func)
			OP_CAS: begin
				upd.new_word         = req.swap_value;
				upd.rsp.return_value = old_word;
				upd.rsp.did_write    = (old_word == req.operand);
			end
			OP_XCHG: begin
				upd.new_word         = req.swap_value;
				upd.rsp.return_value = old_word;
			end
			OP_ADDU: begin
				upd.new_word         = sum;
				upd.rsp.return_value = old_word;
			end
			OP_INC, OP_DEC: begin
				upd.new_word         = sum;
				upd.rsp.return_value = sum;
			end
			OP_MIN: begin
				upd.new_word         = old_lt ? old_word : req.operand;
				upd.rsp.return_value = upd.new_word;
			end
			OP_MAX: begin
				upd.new_word         = (old_word > req.operand) ? old_word : req.operand;
				upd.rsp.return_value = upd.new_word;
			end
			OP_AND: begin
				upd.new_word         = old_word & req.operand;
				upd.rsp.return_value = upd.new_word;
			end
			OP_OR: begin
				upd.new_word         = old_word | req.operand;
				upd.rsp.return_value = upd.new_word;
			end
			OP_XOR: begin
				upd.new_word         = old_word ^ req.operand;
				upd.rsp.return_value = upd.new_word;
			end
			default: begin
				upd.rsp.did_write = 1'b0;
				upd.rsp.bad_func  = 1'b1;
			end
		endcase
	end

endmodule : amu_alu
`default_nettype wire

// ===== hdl/atomic_memory_unit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Atomic memory unit
// Word store with atomic read-modify-write operations, one item at a time.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the store to zero, one word a cycle; req_stall
// stays high during this pass. Each request item then passes through S_DIV,
// which forms the reduction product of the word index, S_ADDR, which reduces
// the index and reads the store, and S_EXEC, which computes and writes back
// and loads the response into the output register, holding while that
// register is full and stalled. A new request is taken in the cycle after
// the previous item has left the store, even while its response still waits
// in the output register. Word indices at or above STORE_WORDS wrap modulo
// STORE_WORDS.
module atomic_memory_unit_top
	import amu_pkg::*;
#(
	parameter int STORE_WORDS = STORE_WORDS_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	output logic      req_stall,
	input  wire amu_req_t req,
	output logic      rsp_valid,
	input  wire       rsp_stall,
	output amu_rsp_t  rsp
);

	localparam int IDX_W   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int CNT_W   = $clog2(STORE_WORDS + 1);
	localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	// Index reduction by reciprocal: the estimate is the quotient or one less.
	localparam int RECIP_SH = 2 * INDEX_W;
	localparam int PROD_W   = RECIP_SH + INDEX_W;
	localparam logic [RECIP_SH-1:0] RECIP   = RECIP_SH'((1 << RECIP_SH) / STORE_WORDS);
	localparam logic [INDEX_W-1:0]  N_LO    = INDEX_W'(STORE_WORDS);
	localparam logic [CMP_W-1:0]    N_CMP   = CMP_W'(STORE_WORDS);
	localparam logic [CNT_W-1:0]    CLR_END = CNT_W'(STORE_WORDS - 1);

	amu_state_t state_q, state_d;

	amu_req_t          req_q;
	logic [PROD_W-1:0] prod_q;
	logic [IDX_W-1:0]  addr_q;
	logic [CNT_W-1:0]  clr_cnt_q;
	logic [WORD_W-1:0] rd_data_q;
	amu_rsp_t          rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              mem_we;
	logic              mem_re;
	logic              load_rsp;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	logic [INDEX_W-1:0] quot;
	logic [INDEX_W-1:0] rem_est;
	logic [CMP_W-1:0]   rem_cmp;
	logic [CMP_W-1:0]   rem_red;
	logic [IDX_W-1:0]   addr_red;

	amu_upd_t upd;

	logic [WORD_W-1:0] mem [STORE_WORDS];

	// Operation logic on the word read from the store.
	amu_alu u_alu (
		.req      (req_q),
		.old_word (rd_data_q),
		.upd      (upd)
	);

	// Index reduction: subtract the estimated multiple, then correct once.
	assign quot     = prod_q[PROD_W-1:RECIP_SH];
	assign rem_est  = req_q.word_index - INDEX_W'(quot * N_LO);
	assign rem_cmp  = CMP_W'(rem_est);
	assign rem_red  = (rem_cmp >= N_CMP) ? (rem_cmp - N_CMP) : rem_cmp;
	assign addr_red = rem_red[IDX_W-1:0];

	// Sequencer next state and controls.
	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		load_rsp  = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = upd.new_word;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q[IDX_W-1:0];
				mem_wdata = '0;
				if (clr_cnt_q == CLR_END) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				accept = req_valid;
				if (req_valid) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				state_d = S_ADDR;
			end
			S_ADDR: begin
				mem_re  = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				// Hold the result until the output register is free.
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					mem_we   = upd.rsp.did_write;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer state, clearing counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + CNT_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request, reduction and response registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_DIV) begin
			prod_q <= PROD_W'(req_q.word_index * RECIP);
		end
		if (state_q == S_ADDR) begin
			addr_q <= addr_red;
		end
		if (load_rsp) begin
			rsp_q <= upd.rsp;
		end
	end

	// Word store: one write and one registered read. Items run one at a
	// time, so a write always lands before the next read of the same word.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[addr_red];
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule : atomic_memory_unit_top
`default_nettype wire
